// File: src/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg
// Shared widths, types and the arctangent table of the tilt angle block.
// ----------------------------------------------------------------------------
package atl_pkg;

   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int CORDIC_STEPS_DEF = 20;

   localparam int FIELD_W  = 16;   // width of each raw sample field
   localparam int EXT_W    = 32;   // raw field zero-extended before the sign pick
   localparam int ROLL_W   = 16;
   localparam int PITCH_W  = 15;

   localparam int VEC_W    = 36;   // cordic vector components
   localparam int ACC_W    = 34;   // angle accumulator, 1/65536 centidegree
   localparam int N_W      = 64;   // radicand
   localparam int ROOT_W   = 32;
   localparam int REM_W    = ROOT_W + 2;
   localparam int SQRT_STEPS = N_W / 2;
   localparam int NUM_LANES  = 2;
   localparam int LANE_ROLL  = 0;
   localparam int LANE_PITCH = 1;
   localparam int TAB_SIZE   = 32;
   localparam int FRAC_SHIFT = 16;

   localparam logic signed [ACC_W-1:0] ANG_90     = ACC_W'(64'sd589824000);
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd32768);
   localparam logic signed [ACC_W-1:0] ANG_MAX    = ACC_W'(64'sd18000);
   localparam logic signed [ACC_W-1:0] ANG_MIN    = -ACC_W'(64'sd18000);

   localparam logic signed [ACC_W-1:0] ATAN_TAB [TAB_SIZE] = '{
      34'sd294912000, 34'sd174096719, 34'sd91987925, 34'sd46694507,
      34'sd23437865,  34'sd11730358,  34'sd5866610,  34'sd2933484,
      34'sd1466764,   34'sd733385,    34'sd366693,   34'sd183346,
      34'sd91673,     34'sd45837,     34'sd22918,    34'sd11459,
      34'sd5730,      34'sd2865,      34'sd1432,     34'sd716,
      34'sd358,       34'sd179,       34'sd90,       34'sd45,
      34'sd22,        34'sd11,        34'sd6,        34'sd3,
      34'sd1,         34'sd1,         34'sd0,        34'sd0
   };

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ACC_W-1:0] acc;
   } lane_type;

   typedef struct packed {
      logic neg_zero;    // roll: y zero and x negative
      logic roll_zero;   // roll: both arguments zero
      logic sq_zero;     // pitch: x and y both zero
      logic z_neg;
   } flags_type;

endpackage

// File: src/atl_req_if.sv
// ----------------------------------------------------------------------------
// atl_req_if
// Sample channel: valid, ready and one accelerometer sample.
// ----------------------------------------------------------------------------
interface atl_req_if import atl_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] accel_x;
   logic signed [FIELD_W-1:0] accel_y;
   logic signed [FIELD_W-1:0] accel_z;

   modport source (output valid, accel_x, accel_y, accel_z, input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

// File: src/atl_rsp_if.sv
// ----------------------------------------------------------------------------
// atl_rsp_if
// Angle channel: valid, ready, roll and pitch.
// ----------------------------------------------------------------------------
interface atl_rsp_if import atl_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [ROLL_W-1:0] roll_centideg;
   logic [PITCH_W-1:0]       pitch_centideg;

   modport source (output valid, roll_centideg, pitch_centideg, input ready);
   modport sink   (input valid, roll_centideg, pitch_centideg, output ready);
endinterface

// File: src/accel_tilt_angles_top.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles_top
// Roll and pitch of one accelerometer sample, in hundredths of a degree.
// ----------------------------------------------------------------------------
// usage:
//   req_ch takes one sample (accel_x, accel_y, accel_z) per valid/ready item;
//   rsp_ch gives one item (roll_centideg, pitch_centideg) per sample, in order.
//   roll = atan2(-y, x) in -18000..18000, pitch = atan2(sqrt(x^2+y^2), z) in
//   0..18000, rounded to nearest.
// pipeline:
//   from accept to rsp_ch.valid an item passes the squaring register (stage a),
//   the sum register (stage b), 32 square root cells, one cordic cell per step,
//   then the output register.
// throughput:
//   one item per clock while rsp_ch is ready; every stage is a register with its own valid.
// stall:
//   each stage loads whenever it is empty or its successor moves, so bubbles
//   close up and req_ch keeps accepting while a result waits in the output
//   register, until every stage is full.
// reset:
//   synchronous, clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module accel_tilt_angles_top import atl_pkg::*; #(
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   atl_req_if.sink   req_ch,
   atl_rsp_if.source rsp_ch
);

   localparam int GUARD   = 32 - SAMPLE_BITS;
   localparam int SQ_W    = 2 * SAMPLE_BITS + 1;
   localparam int PASS_W  = $bits(flags_type);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] z;
      logic                          sq_zero;
      lane_type                      roll;
      logic                          neg_zero;
      logic                          roll_zero;
   } side_type;

   localparam int SIDE_W = $bits(side_type);

   // ---------------- stage a: sign pick, squares, roll prerotation
   logic signed [SAMPLE_BITS-1:0]   xs, ys, zs;
   logic signed [VEC_W-1:0]         rx, ry;
   lane_type                        roll_pre;
   logic                            a_valid_ff, a_ready;
   logic [2*SAMPLE_BITS-1:0]        a_xx_ff, a_yy_ff;
   logic signed [SAMPLE_BITS-1:0]   a_z_ff;
   lane_type                        a_roll_ff;
   logic                            a_neg0_ff, a_rzero_ff;

   // ---------------- stage b: sum and radicand
   logic                            b_valid_ff, b_ready;
   logic [SQ_W-1:0]                 sq;
   logic [N_W-1:0]                  b_n_ff;
   side_type                        b_side_ff;

   assign xs = SAMPLE_BITS'(EXT_W'(unsigned'(req_ch.accel_x)));
   assign ys = SAMPLE_BITS'(EXT_W'(unsigned'(req_ch.accel_y)));
   assign zs = SAMPLE_BITS'(EXT_W'(unsigned'(req_ch.accel_z)));

   always_comb begin
      rx = VEC_W'(xs) <<< GUARD;
      ry = -(VEC_W'(ys) <<< GUARD);
      roll_pre.x   = rx;
      roll_pre.y   = ry;
      roll_pre.acc = '0;
      if (rx < 0) begin
         if (ry >= 0) begin
            roll_pre.x   = ry;
            roll_pre.y   = -rx;
            roll_pre.acc = ANG_90;
         end else begin
            roll_pre.x   = -ry;
            roll_pre.y   = rx;
            roll_pre.acc = -ANG_90;
         end
      end
   end

   assign a_ready       = !a_valid_ff || b_ready;
   assign req_ch.ready  = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_xx_ff    <= unsigned'((2*SAMPLE_BITS)'(xs) * (2*SAMPLE_BITS)'(xs));
         a_yy_ff    <= unsigned'((2*SAMPLE_BITS)'(ys) * (2*SAMPLE_BITS)'(ys));
         a_z_ff     <= zs;
         a_roll_ff  <= roll_pre;
         a_neg0_ff  <= (ys == '0) && (xs < 0);
         a_rzero_ff <= (ys == '0) && (xs == '0);
      end
   end

   assign sq = SQ_W'(a_xx_ff) + SQ_W'(a_yy_ff);

   // sqrt chain wiring
   logic                sq_valid [SQRT_STEPS+1];
   logic                sq_ready [SQRT_STEPS+1];
   logic [N_W-1:0]      sq_n     [SQRT_STEPS+1];
   logic [REM_W-1:0]    sq_rem   [SQRT_STEPS+1];
   logic [ROOT_W-1:0]   sq_root  [SQRT_STEPS+1];
   logic [SIDE_W-1:0]   sq_pass  [SQRT_STEPS+1];

   assign b_ready = !b_valid_ff || sq_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready) begin
         b_n_ff              <= N_W'(sq) << (2 * GUARD);
         b_side_ff.z         <= a_z_ff;
         b_side_ff.sq_zero   <= (sq == '0);
         b_side_ff.roll      <= a_roll_ff;
         b_side_ff.neg_zero  <= a_neg0_ff;
         b_side_ff.roll_zero <= a_rzero_ff;
      end
   end

   assign sq_valid[0] = b_valid_ff;
   assign sq_n[0]     = b_n_ff;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_pass[0]  = b_side_ff;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      atl_sqrt_cell #(.PASS_W(SIDE_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[k]),
         .in_ready  (sq_ready[k]),
         .in_n      (sq_n[k]),
         .in_rem    (sq_rem[k]),
         .in_root   (sq_root[k]),
         .in_pass   (sq_pass[k]),
         .out_valid (sq_valid[k+1]),
         .out_ready (sq_ready[k+1]),
         .out_n     (sq_n[k+1]),
         .out_rem   (sq_rem[k+1]),
         .out_root  (sq_root[k+1]),
         .out_pass  (sq_pass[k+1])
      );
   end

   // ---------------- pitch prerotation at the head of the cordic chain
   side_type                sq_side;
   logic signed [VEC_W-1:0] px, py;
   flags_type               head_flags;

   logic                cd_valid [CORDIC_STEPS+1];
   logic                cd_ready [CORDIC_STEPS+1];
   lane_type            cd_lane  [CORDIC_STEPS+1][NUM_LANES];
   logic [PASS_W-1:0]   cd_pass  [CORDIC_STEPS+1];

   assign sq_side = side_type'(sq_pass[SQRT_STEPS]);
   assign px = VEC_W'(sq_side.z) <<< GUARD;
   assign py = signed'(VEC_W'(sq_root[SQRT_STEPS]));

   always_comb begin
      cd_lane[0][LANE_ROLL] = sq_side.roll;
      if (px < 0) begin
         // radius is never negative, so only the upper half plane turn
         cd_lane[0][LANE_PITCH].x   = py;
         cd_lane[0][LANE_PITCH].y   = -px;
         cd_lane[0][LANE_PITCH].acc = ANG_90;
      end else begin
         cd_lane[0][LANE_PITCH].x   = px;
         cd_lane[0][LANE_PITCH].y   = py;
         cd_lane[0][LANE_PITCH].acc = '0;
      end
      head_flags.neg_zero  = sq_side.neg_zero;
      head_flags.roll_zero = sq_side.roll_zero;
      head_flags.sq_zero   = sq_side.sq_zero;
      head_flags.z_neg     = sq_side.z < 0;
   end

   assign cd_valid[0]        = sq_valid[SQRT_STEPS];
   assign sq_ready[SQRT_STEPS] = cd_ready[0];
   assign cd_pass[0]         = head_flags;

   for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
      atl_cordic_cell #(.STEP(s), .PASS_W(PASS_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cd_valid[s]),
         .in_ready  (cd_ready[s]),
         .in_lane   (cd_lane[s]),
         .in_pass   (cd_pass[s]),
         .out_valid (cd_valid[s+1]),
         .out_ready (cd_ready[s+1]),
         .out_lane  (cd_lane[s+1]),
         .out_pass  (cd_pass[s+1])
      );
   end

   // ---------------- rounding, clamp, special cases, output register
   flags_type               tail_flags;
   logic signed [ACC_W-1:0] roll_rnd, pitch_rnd;
   logic signed [ACC_W-1:0] roll_val, pitch_val;
   logic                    out_valid_ff;
   logic signed [ROLL_W-1:0] roll_ff;
   logic [PITCH_W-1:0]       pitch_ff;
   logic                    out_load;

   assign tail_flags = flags_type'(cd_pass[CORDIC_STEPS]);
   assign roll_rnd  = (cd_lane[CORDIC_STEPS][LANE_ROLL].acc + ROUND_HALF) >>> FRAC_SHIFT;
   assign pitch_rnd = (cd_lane[CORDIC_STEPS][LANE_PITCH].acc + ROUND_HALF) >>> FRAC_SHIFT;

   always_comb begin
      if (tail_flags.neg_zero) begin
         roll_val = ANG_MIN;
      end else if (tail_flags.roll_zero) begin
         roll_val = '0;
      end else if (roll_rnd > ANG_MAX) begin
         roll_val = ANG_MAX;
      end else if (roll_rnd < ANG_MIN) begin
         roll_val = ANG_MIN;
      end else begin
         roll_val = roll_rnd;
      end

      if (tail_flags.sq_zero) begin
         pitch_val = tail_flags.z_neg ? ANG_MAX : '0;
      end else if (pitch_rnd > ANG_MAX) begin
         pitch_val = ANG_MAX;
      end else if (pitch_rnd < 0) begin
         pitch_val = '0;
      end else begin
         pitch_val = pitch_rnd;
      end
   end

   assign out_load               = !out_valid_ff || rsp_ch.ready;
   assign cd_ready[CORDIC_STEPS] = out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= cd_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         roll_ff  <= ROLL_W'(roll_val);
         pitch_ff <= PITCH_W'(pitch_val);
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.roll_centideg  = roll_ff;
   assign rsp_ch.pitch_centideg = pitch_ff;

endmodule

// File: src/atl_sqrt_cell.sv
// ----------------------------------------------------------------------------
// atl_sqrt_cell
// One digit of a pipelined square root: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module atl_sqrt_cell import atl_pkg::*; #(
   parameter int PASS_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [N_W-1:0]      in_n,
   input  logic [REM_W-1:0]    in_rem,
   input  logic [ROOT_W-1:0]   in_root,
   input  logic [PASS_W-1:0]   in_pass,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [N_W-1:0]      out_n,
   output logic [REM_W-1:0]    out_rem,
   output logic [ROOT_W-1:0]   out_root,
   output logic [PASS_W-1:0]   out_pass
);

   logic              valid_ff;
   logic [N_W-1:0]    n_ff, n_in;
   logic [REM_W-1:0]  rem_ff, rem_in, rem_sh, trial;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [PASS_W-1:0] pass_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      rem_sh = {in_rem[REM_W-3:0], in_n[N_W-1 -: 2]};
      trial  = {in_root, 2'b01};
      n_in   = {in_n[N_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {in_root[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {in_root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         n_ff    <= n_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         pass_ff <= in_pass;
      end
   end

   assign out_valid = valid_ff;
   assign out_n     = n_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_pass  = pass_ff;

endmodule

// File: src/atl_cordic_cell.sv
// ----------------------------------------------------------------------------
// atl_cordic_cell
// One vectoring cordic iteration on the roll and pitch lanes side by side.
// ----------------------------------------------------------------------------
module atl_cordic_cell import atl_pkg::*; #(
   parameter int STEP   = 0,
   parameter int PASS_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  lane_type          in_lane [NUM_LANES],
   input  logic [PASS_W-1:0] in_pass,
   output logic              out_valid,
   input  logic              out_ready,
   output lane_type          out_lane [NUM_LANES],
   output logic [PASS_W-1:0] out_pass
);

   logic              valid_ff;
   lane_type          lane_ff [NUM_LANES];
   lane_type          lane_in [NUM_LANES];
   logic [PASS_W-1:0] pass_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         if (in_lane[l].y > 0) begin
            lane_in[l].x   = in_lane[l].x + (in_lane[l].y >>> STEP);
            lane_in[l].y   = in_lane[l].y - (in_lane[l].x >>> STEP);
            lane_in[l].acc = in_lane[l].acc + ATAN_TAB[STEP];
         end else begin
            lane_in[l].x   = in_lane[l].x - (in_lane[l].y >>> STEP);
            lane_in[l].y   = in_lane[l].y + (in_lane[l].x >>> STEP);
            lane_in[l].acc = in_lane[l].acc - ATAN_TAB[STEP];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         lane_ff <= lane_in;
         pass_ff <= in_pass;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;
   assign out_pass  = pass_ff;

endmodule
